@@ rtl/bphc_pkg.sv @@
// ----------------------------------------------------------------------------
// bphc_pkg
// Shared widths, reset values and register indexes for the button press and
// hold classifier.
// ----------------------------------------------------------------------------
package bphc_pkg;

    localparam int BUTTON_COUNT_DEF = 2;
    localparam int TICK_W           = 32;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_W-1:0] HOLD_RESET     = CFG_W'(1000);
    localparam logic [CFG_W-1:0] COOLDOWN_RESET = CFG_W'(200);

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS = 1'b1;

endpackage

@@ rtl/button_press_hold_classifier_top.sv @@
// ----------------------------------------------------------------------------
// button_press_hold_classifier_top
// Classifies button activity into short presses and long presses.
// ----------------------------------------------------------------------------
// Each input transfer is one check carrying a changed flag, the current tick
// and the button levels. A check is taken into an input register, classified
// against the per-button state once the drain can take its results, and its
// results are then handed out one per output transfer, lowest button first,
// with last_in_run set on the final result of the check. Checks that cause no
// result can follow each other in every cycle; a check that causes results
// holds the classifier until the output register has taken its last result,
// which it takes one per cycle while the output side does not stall. The first
// result passes the input register, the drain and the output register in order.
// The user must write the hold_ticks and cooldown_ticks registers through the
// plain write port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_press_hold_classifier_top #(
    parameter int BUTTON_COUNT = bphc_pkg::BUTTON_COUNT_DEF,
    parameter int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [bphc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bphc_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_in_changed,
    input  logic [bphc_pkg::TICK_W-1:0]    i_in_now_tick,
    input  logic [BUTTON_COUNT-1:0]        i_in_button_levels,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [IDX_W-1:0]               o_out_button_index,
    output logic                           o_out_is_hold,
    output logic                           o_out_last_in_run
);
    import bphc_pkg::*;

    logic [CFG_W-1:0]        r_hold_ticks;
    logic [CFG_W-1:0]        r_cooldown_ticks;

    logic                    r_in_valid;
    logic                    r_in_changed;
    logic [TICK_W-1:0]       r_in_now_tick;
    logic [BUTTON_COUNT-1:0] r_in_levels;

    logic                    drain_free;
    logic                    eval;
    logic                    in_take;
    logic [BUTTON_COUNT-1:0] emit_mask;
    logic [BUTTON_COUNT-1:0] hold_mask;

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks     <= HOLD_RESET;
            r_cooldown_ticks <= COOLDOWN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOLD_TICKS:     r_hold_ticks     <= i_cfg_wdata;
                REG_COOLDOWN_TICKS: r_cooldown_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The held check is classified once the drain can take its results,
    // which frees the input register in the same cycle for the next check.
    assign eval       = r_in_valid && drain_free;
    assign o_in_stall = r_in_valid && !drain_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (eval) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_changed  <= i_in_changed;
            r_in_now_tick <= i_in_now_tick;
            r_in_levels   <= i_in_button_levels;
        end
    end

    bphc_core #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_eval           (eval),
        .i_changed        (r_in_changed),
        .i_now_tick       (r_in_now_tick),
        .i_button_levels  (r_in_levels),
        .i_hold_ticks     (r_hold_ticks),
        .i_cooldown_ticks (r_cooldown_ticks),
        .o_emit_mask      (emit_mask),
        .o_hold_mask      (hold_mask)
    );

    // Results of one check wait here and leave one per output transfer.
    bphc_drain #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .IDX_W        (IDX_W)
    ) u_drain (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (eval),
        .i_emit_mask        (emit_mask),
        .i_hold_mask        (hold_mask),
        .o_free             (drain_free),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_button_index (o_out_button_index),
        .o_out_is_hold      (o_out_is_hold),
        .o_out_last_in_run  (o_out_last_in_run)
    );

endmodule

@@ rtl/bphc_core.sv @@
// ----------------------------------------------------------------------------
// bphc_core
// Per-button state and classification of one registered check.
// ----------------------------------------------------------------------------
module bphc_core #(
    parameter int BUTTON_COUNT = bphc_pkg::BUTTON_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_eval,
    input  logic                        i_changed,
    input  logic [bphc_pkg::TICK_W-1:0] i_now_tick,
    input  logic [BUTTON_COUNT-1:0]     i_button_levels,
    input  logic [bphc_pkg::CFG_W-1:0]  i_hold_ticks,
    input  logic [bphc_pkg::CFG_W-1:0]  i_cooldown_ticks,
    output logic [BUTTON_COUNT-1:0]     o_emit_mask,
    output logic [BUTTON_COUNT-1:0]     o_hold_mask
);
    import bphc_pkg::*;

    logic [BUTTON_COUNT-1:0] r_prev_level, n_prev_level;
    logic [BUTTON_COUNT-1:0] r_armed, n_armed;
    logic [TICK_W-1:0]       r_press_time  [BUTTON_COUNT];
    logic [TICK_W-1:0]       n_press_time  [BUTTON_COUNT];
    logic [TICK_W-1:0]       r_action_time [BUTTON_COUNT];
    logic [TICK_W-1:0]       n_action_time [BUTTON_COUNT];

    always_comb begin
        logic [TICK_W-1:0] since_press;
        logic [TICK_W-1:0] since_action;
        n_prev_level = r_prev_level;
        n_armed      = r_armed;
        o_emit_mask  = '0;
        o_hold_mask  = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_press_time[i]  = r_press_time[i];
            n_action_time[i] = r_action_time[i];
            since_press  = i_now_tick - r_press_time[i];
            since_action = i_now_tick - r_action_time[i];
            if (i_changed) begin
                if (i_button_levels[i]) begin
                    if (!r_prev_level[i]) begin
                        n_press_time[i] = i_now_tick;
                        n_armed[i]      = 1'b1;
                    end
                end else if (r_prev_level[i] && r_armed[i] &&
                             since_action >= TICK_W'(i_cooldown_ticks)) begin
                    o_emit_mask[i]   = 1'b1;
                    n_armed[i]       = 1'b0;
                    n_action_time[i] = i_now_tick;
                end
                n_prev_level[i] = i_button_levels[i];
            end else if (r_prev_level[i] && r_armed[i] &&
                         since_press >= TICK_W'(i_hold_ticks)) begin
                o_emit_mask[i]   = 1'b1;
                o_hold_mask[i]   = 1'b1;
                n_armed[i]       = 1'b0;
                n_action_time[i] = i_now_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= '0;
            r_armed      <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_press_time[i]  <= '0;
                r_action_time[i] <= '0;
            end
        end else if (i_eval) begin
            r_prev_level <= n_prev_level;
            r_armed      <= n_armed;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_press_time[i]  <= n_press_time[i];
                r_action_time[i] <= n_action_time[i];
            end
        end
    end

endmodule

@@ rtl/bphc_drain.sv @@
// ----------------------------------------------------------------------------
// bphc_drain
// Holds the results of one check and hands them out one per transfer, lowest
// button first, through the output register.
// ----------------------------------------------------------------------------
module bphc_drain #(
    parameter int BUTTON_COUNT = bphc_pkg::BUTTON_COUNT_DEF,
    parameter int IDX_W        = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [BUTTON_COUNT-1:0] i_emit_mask,
    input  logic [BUTTON_COUNT-1:0] i_hold_mask,
    output logic                    o_free,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_out_button_index,
    output logic                    o_out_is_hold,
    output logic                    o_out_last_in_run
);
    logic [BUTTON_COUNT-1:0] r_pend;
    logic [BUTTON_COUNT-1:0] r_hold;
    logic [BUTTON_COUNT-1:0] low_bit;
    logic [BUTTON_COUNT-1:0] rem;
    logic [IDX_W-1:0]        low_idx;
    logic                    pop;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_hold;
    logic                    r_out_last;

    always_comb begin
        low_bit = r_pend & (~r_pend + BUTTON_COUNT'(1));
        rem     = r_pend & ~low_bit;
        low_idx = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign pop    = (|r_pend) && (!r_out_valid || !i_out_stall);
    assign o_free = (r_pend == '0) || (pop && (rem == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_pend <= i_emit_mask;
            end else if (pop) begin
                r_pend <= rem;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hold <= i_hold_mask;
        end
        if (pop) begin
            r_out_idx  <= low_idx;
            r_out_hold <= |(low_bit & r_hold);
            r_out_last <= (rem == '0);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_button_index = r_out_idx;
    assign o_out_is_hold      = r_out_hold;
    assign o_out_last_in_run  = r_out_last;

endmodule

@@ sim/tb_button_press_hold_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_hold_classifier_top
// Self-checking bench for the button short and long press classifier.
// ----------------------------------------------------------------------------
// Checks are queued by a stimulus process and presented by a driver that
// idles at random between transfers. Every accepted check is classified by
// a behavioural copy of the per-button state, and the press events that it
// should cause are queued. A monitor takes results under random stall and
// compares each one, field by field, with the oldest awaited event. The
// run goes through several hold and cooldown settings, the extremes among
// them, and writes the registers only while the block is idle.
// ----------------------------------------------------------------------------
module tb_button_press_hold_classifier_top;
    import bphc_pkg::*;

    localparam int          NUM_BUTTONS  = 2;
    localparam int          CLK_HALF_NS  = 6;
    localparam int          IDLE_TAIL    = 8;
    localparam int          PHASE_CHECKS = 206;
    localparam int          NUM_PHASES   = 7;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic                   changed;
        logic [TICK_W-1:0]      now_tick;
        logic [NUM_BUTTONS-1:0] levels;
    } t_check;

    typedef struct packed {
        logic button_index;
        logic is_hold;
        logic last_in_run;
    } t_press_event;

    logic                   i_clk              = 1'b0;
    logic                   i_rst_n            = 1'b0;
    logic                   i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index        = '0;
    logic [CFG_W-1:0]       i_cfg_wdata        = '0;
    logic                   i_in_valid         = 1'b0;
    logic                   o_in_stall;
    logic                   i_in_changed       = 1'b0;
    logic [TICK_W-1:0]      i_in_now_tick      = '0;
    logic [NUM_BUTTONS-1:0] i_in_button_levels = '0;
    logic                   o_out_valid;
    logic                   i_out_stall        = 1'b0;
    logic                   o_out_button_index;
    logic                   o_out_is_hold;
    logic                   o_out_last_in_run;

    button_press_hold_classifier_top #(
        .BUTTON_COUNT(NUM_BUTTONS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_changed       (i_in_changed),
        .i_in_now_tick      (i_in_now_tick),
        .i_in_button_levels (i_in_button_levels),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_button_index (o_out_button_index),
        .o_out_is_hold      (o_out_is_hold),
        .o_out_last_in_run  (o_out_last_in_run)
    );

    // Checks waiting to be presented, and press events waiting to come out.
    t_check       pending_checks[$];
    t_press_event awaited_presses[$];

    int checks_sent     = 0;
    int checks_accepted = 0;
    int results_taken   = 0;
    int fail_count      = 0;

    // Behavioural copy of the classifier state and its two registers.
    logic [CFG_W-1:0]       hold_cfg;
    logic [CFG_W-1:0]       cooldown_cfg;
    logic [NUM_BUTTONS-1:0] btn_level;
    logic [NUM_BUTTONS-1:0] btn_armed;
    logic [TICK_W-1:0]      press_tick  [NUM_BUTTONS];
    logic [TICK_W-1:0]      action_tick [NUM_BUTTONS];

    // Stimulus generator's own view of time and of the levels it drives.
    logic [TICK_W-1:0]      gen_tick;
    logic [NUM_BUTTONS-1:0] gen_levels;

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // A generous ceiling: several times the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // Idle length for one transfer. Now and then a stretch of transfers with
    // no idling at all is inserted so that back-to-back traffic is covered.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Classifies one accepted check against the tracked state and queues the
    // press events it causes, lowest button first, the final one flagged.
    function automatic void classify_check(t_check c);
        t_press_event run[$];
        t_press_event ev;
        logic [TICK_W-1:0] since;

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            ev = '0;
            ev.button_index = b[0];
            if (c.changed) begin
                since = c.now_tick - action_tick[b];
                if (c.levels[b]) begin
                    if (!btn_level[b]) begin
                        press_tick[b] = c.now_tick;
                        btn_armed[b]  = 1'b1;
                    end
                end else if (btn_level[b] && btn_armed[b] &&
                             since >= TICK_W'(cooldown_cfg)) begin
                    // Short press: released after the cooldown has run out.
                    run.push_back(ev);
                    btn_armed[b]   = 1'b0;
                    action_tick[b] = c.now_tick;
                end
                btn_level[b] = c.levels[b];
            end else begin
                // A poll leaves the recorded levels alone.
                since = c.now_tick - press_tick[b];
                if (btn_level[b] && btn_armed[b] && since >= TICK_W'(hold_cfg)) begin
                    ev.is_hold = 1'b1;
                    run.push_back(ev);
                    btn_armed[b]   = 1'b0;
                    action_tick[b] = c.now_tick;
                end
            end
        end
        if (run.size() > 0) begin
            run[run.size()-1].last_in_run = 1'b1;
        end
        foreach (run[k]) begin
            awaited_presses.push_back(run[k]);
        end
    endfunction

    // Input driver: presents queued checks, changing them only on the falling
    // edge and holding each one until its transfer has been seen.
    int in_gap_left  = 0;
    int in_calm_left = 0;

    always @(negedge i_clk) begin : check_driver
        logic   next_valid;
        t_check nxt;

        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && checks_accepted == checks_sent) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                end else if (pending_checks.size() > 0) begin
                    nxt = pending_checks.pop_front();
                    i_in_changed       <= nxt.changed;
                    i_in_now_tick      <= nxt.now_tick;
                    i_in_button_levels <= nxt.levels;
                    next_valid  = 1'b1;
                    checks_sent++;
                    in_gap_left = draw_idle(in_calm_left);
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Every input transfer is classified at the edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            classify_check('{i_in_changed, i_in_now_tick, i_in_button_levels});
            checks_accepted++;
        end
    end

    // Output stall: after each result transfer a fresh number of stalled
    // cycles is drawn for the next one.
    int stall_left    = 0;
    int stall_seen    = 0;
    int out_calm_left = 0;

    always @(negedge i_clk) begin
        if (results_taken != stall_seen) begin
            stall_seen = results_taken;
            stall_left = draw_idle(out_calm_left);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : press_monitor
        t_press_event want;

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_taken++;
            if (awaited_presses.size() == 0) begin
                $error("unexpected result: button_index %0d is_hold %0d last_in_run %0d",
                       o_out_button_index, o_out_is_hold, o_out_last_in_run);
                fail_count++;
            end else begin
                want = awaited_presses.pop_front();
                if (o_out_button_index !== want.button_index) begin
                    $error("button_index: expected %0d, actual %0d",
                           want.button_index, o_out_button_index);
                    fail_count++;
                end
                if (o_out_is_hold !== want.is_hold) begin
                    $error("is_hold: expected %0d, actual %0d", want.is_hold, o_out_is_hold);
                    fail_count++;
                end
                if (o_out_last_in_run !== want.last_in_run) begin
                    $error("last_in_run: expected %0d, actual %0d",
                           want.last_in_run, o_out_last_in_run);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_check(logic chg, logic [TICK_W-1:0] tick, logic [NUM_BUTTONS-1:0] lv);
        pending_checks.push_back('{chg, tick, lv});
    endtask

    // Tick advance between checks. Some steps are drawn around the current
    // hold and cooldown so that both thresholds are hit from either side; a
    // few are huge so that the tick wraps.
    function automatic logic [TICK_W-1:0] pick_delta();
        case ($urandom_range(0, 6))
            0: return TICK_W'($urandom_range(0, 3));
            1: return TICK_W'(hold_cfg) + TICK_W'($urandom_range(0, 4)) - TICK_W'(2);
            2: return TICK_W'(cooldown_cfg) + TICK_W'($urandom_range(0, 4)) - TICK_W'(2);
            3: return TICK_W'($urandom_range(0, hold_cfg));
            4: return TICK_W'($urandom_range(0, cooldown_cfg));
            5: return TICK_W'($urandom_range(0, 400));
            default: return TICK_W'($urandom);
        endcase
    endfunction

    // Mostly coherent press and release sequences on an advancing tick, with
    // polls in between; about one check in ten is pure noise.
    task automatic fill_random(int n);
        int sel;
        logic [NUM_BUTTONS-1:0] mask;

        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                push_check(1'($urandom_range(0, 1)), TICK_W'($urandom),
                           NUM_BUTTONS'($urandom_range(0, 3)));
            end else begin
                gen_tick = gen_tick + pick_delta();
                if (sel < 55) begin
                    mask = ($urandom_range(0, 7) == 0) ? '0 : NUM_BUTTONS'($urandom_range(1, 3));
                    gen_levels = gen_levels ^ mask;
                    push_check(1'b1, gen_tick, gen_levels);
                end else begin
                    // Levels on a poll are ignored by the block, so they are noise.
                    push_check(1'b0, gen_tick, NUM_BUTTONS'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    // Waits until every queued check has been taken and every awaited event
    // has come out, then lets a check without results finish its pass.
    task automatic wait_idle();
        while (pending_checks.size() != 0 || checks_accepted != checks_sent ||
               awaited_presses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_HOLD_TICKS:     hold_cfg     = data;
            REG_COOLDOWN_TICKS: cooldown_cfg = data;
            default: ;
        endcase
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] hold_plan     [NUM_PHASES];
        logic [CFG_W-1:0] cooldown_plan [NUM_PHASES];

        hold_cfg     = HOLD_RESET;
        cooldown_cfg = COOLDOWN_RESET;
        btn_level    = '0;
        btn_armed    = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_tick[b]  = '0;
            action_tick[b] = '0;
        end
        gen_tick   = TICK_W'($urandom);
        gen_levels = '0;

        hold_plan     = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd10, 16'd0, 16'd1000};
        cooldown_plan = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd3, 16'd0, 16'd200};
        hold_plan[5]     = CFG_W'($urandom_range(0, 65535));
        cooldown_plan[5] = CFG_W'($urandom_range(0, 65535));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks under the reset values of hold and cooldown.
        push_check(1'b0, 32'd0,          2'b11); // poll with nothing pressed
        push_check(1'b1, 32'd5,          2'b01); // press button 0
        push_check(1'b1, 32'd10,         2'b00); // release inside cooldown: silent
        push_check(1'b0, 32'd5000,       2'b01); // poll while released: silent
        push_check(1'b1, 32'd300,        2'b01); // re-press records a new press time
        push_check(1'b1, 32'd300,        2'b01); // unchanged level: nothing happens
        push_check(1'b1, 32'd400,        2'b00); // short press on button 0
        push_check(1'b1, 32'd500,        2'b11); // press both buttons
        push_check(1'b0, 32'd1499,       2'b00); // one tick short of the hold time
        push_check(1'b0, 32'd1500,       2'b00); // long press on both in one check
        push_check(1'b1, 32'd1600,       2'b00); // release after hold: disarmed
        push_check(1'b1, 32'd2000,       2'b10); // press button 1
        push_check(1'b1, 32'hFFFF_FFFF,  2'b11); // press button 0 at the top tick
        push_check(1'b1, 32'h0000_00C7,  2'b00); // both short, action gap wraps
        push_check(1'b1, 32'hFFFF_FF00,  2'b01); // press button 0 before the wrap
        push_check(1'b0, 32'h0000_02E7,  2'b10); // held across the wrap, not long enough
        push_check(1'b0, 32'h0000_02E8,  2'b10); // long press across the wrap
        push_check(1'b0, 32'hFFFF_FFFF,  2'b10); // poll, nothing armed
        push_check(1'b1, 32'hAAAA_5555,  2'b10); // press button 1 only
        push_check(1'b1, 32'h5555_AAAA,  2'b01); // swap: button 1 short, button 0 press
        fill_random(PHASE_CHECKS - 20);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_HOLD_TICKS, hold_plan[p]);
            write_reg(REG_COOLDOWN_TICKS, cooldown_plan[p]);
            fill_random(PHASE_CHECKS);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ button_press_hold_classifier_top.f @@
rtl/bphc_pkg.sv
rtl/bphc_core.sv
rtl/bphc_drain.sv
rtl/button_press_hold_classifier_top.sv
sim/tb_button_press_hold_classifier_top.sv
